// File: rtl/core/frd_pkg.sv
// ----------------------------------------------------------------------------
// frd_pkg: shared types and constants of the file record deframer
// Character codes, result kinds, error codes and the result item layout.
// ----------------------------------------------------------------------------
package frd_pkg;

    localparam int DIGEST_CHARS = 32;
    localparam int DIGEST_CNT_W = 6;

    localparam logic [7:0] CHAR_FILE = 8'h66;   // 'f'
    localparam logic [7:0] CHAR_DIR  = 8'h64;   // 'd'
    localparam logic [7:0] CHAR_STOP = 8'h78;   // 'x'
    localparam logic [7:0] CHAR_DOT  = 8'h2e;   // '.'
    localparam logic [7:0] CHAR_SLSH = 8'h2f;   // '/'
    localparam logic [7:0] CHAR_SUBS = 8'h64;   // 'd', replaces dots and slashes

    localparam logic [19:0] MAX_NAME_RST = 20'd1000000;

    localparam logic [2:0] KIND_EVENT = 3'd0;
    localparam logic [2:0] KIND_FNAME = 3'd1;
    localparam logic [2:0] KIND_DNAME = 3'd2;
    localparam logic [2:0] KIND_DIGST = 3'd3;
    localparam logic [2:0] KIND_DATA  = 3'd4;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_TYPE  = 2'd1;
    localparam logic [1:0] ERR_NLEN  = 2'd2;
    localparam logic [1:0] ERR_SIZE  = 2'd3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] byte_kind;
        logic       field_last;
        logic       record_done;
        logic       stop_seen;
        logic [1:0] error_code;
        logic       run_last;
    } result_t;

    function automatic result_t make_res(
        input logic [7:0] byte_val,
        input logic [2:0] kind,
        input logic       last,
        input logic       done,
        input logic       stop,
        input logic [1:0] err
    );
        result_t r;
        r.out_byte    = byte_val;
        r.byte_kind   = kind;
        r.field_last  = last;
        r.record_done = done;
        r.stop_seen   = stop;
        r.error_code  = err;
        r.run_last    = 1'b0;
        return r;
    endfunction

endpackage

// File: rtl/core/frd_ifs.sv
// ----------------------------------------------------------------------------
// frd_ifs: stream interfaces of the file record deframer
// Input byte channel and result item channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface frd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface frd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] byte_kind;
    logic       field_last;
    logic       record_done;
    logic       stop_seen;
    logic [1:0] error_code;
    logic       run_last;

    modport source (output valid, output out_byte, output byte_kind, output field_last,
                    output record_done, output stop_seen, output error_code,
                    output run_last, input ready);
    modport sink   (input valid, input out_byte, input byte_kind, input field_last,
                    input record_done, input stop_seen, input error_code,
                    input run_last, output ready);
endinterface

// File: rtl/core/file_record_deframer.sv
// ----------------------------------------------------------------------------
// file_record_deframer: splits a received byte stream into records
// Parses type, name length, name (sanitized), size, digest and data bytes
// and emits one result item per payload byte plus event items.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+-------------------------------------------
//  rx      | in  | valid / ready  | rx_byte
//  res     | out | valid / ready  | out_byte, byte_kind, field_last,
//          |     |                | record_done, stop_seen, error_code, run_last
//  cfg     | in  | cfg_we         | cfg_wdata (max_name_length)
//
//  One input byte per cycle while rx.ready is high. The parse step and its
//  results are computed in the accept cycle and written into a 4-entry
//  result queue, from which res is read in order.
//  rx.ready is high while the queue holds at most one item, so a steady
//  one-result-per-byte stream runs at full rate; the name's final byte
//  (up to 3 results) may stall rx until the queue drains.
//  Reset empties the queue and returns the parser to the record type byte.
//  After a stop or error item every further byte is taken and dropped.
//
module file_record_deframer (
    input  logic               clk,
    input  logic               rst_n,
    frd_in_if.sink             rx,
    frd_out_if.source          res,
    input  logic               cfg_we,
    input  logic [19:0]        cfg_wdata
);
    import frd_pkg::*;

    // parser phases
    localparam logic [3:0] PH_TYPE    = 4'd0;
    localparam logic [3:0] PH_NAMELEN = 4'd1;
    localparam logic [3:0] PH_NAME    = 4'd2;
    localparam logic [3:0] PH_SIZE    = 4'd3;
    localparam logic [3:0] PH_DIGEST  = 4'd4;
    localparam logic [3:0] PH_SEP     = 4'd5;
    localparam logic [3:0] PH_DATA    = 4'd6;
    localparam logic [3:0] PH_STOP    = 4'd7;
    localparam logic [3:0] PH_ERROR   = 4'd8;

    // parser state
    logic [19:0]             max_name_reg;
    logic [3:0]              phase_reg,     phase_next;
    logic                    is_dir_reg,    is_dir_next;
    logic [1:0]              hdr_cnt_reg,   hdr_cnt_next;
    logic [31:0]             shift_reg,     shift_next;
    logic [19:0]             name_len_reg,  name_len_next;
    logic [19:0]             name_cnt_reg,  name_cnt_next;
    logic [7:0]              win_reg [2];   // name lookahead, no reset needed
    logic [7:0]              win_next [2];
    logic [1:0]              fill_reg,      fill_next;
    logic [30:0]             file_len_reg,  file_len_next;
    logic [30:0]             data_cnt_reg,  data_cnt_next;
    logic [DIGEST_CNT_W-1:0] dig_cnt_reg,   dig_cnt_next;

    // result queue
    result_t    q_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] q_cnt_reg;

    logic       accept;
    logic       pop;
    logic [1:0] n_res;
    result_t    res_item [3];

    // per-byte helpers
    logic [7:0]  b;
    logic [31:0] shifted;
    logic        name_end;
    logic [2:0]  name_kind;
    logic [30:0] data_inc;
    logic        data_last;
    logic        dig_last;
    logic [7:0]  a0, a1, a2;       // name tail before cleaning
    logic [7:0]  c0, c1, c2;       // name tail after cleaning

    assign accept   = rx.valid && rx.ready;
    assign pop      = res.valid && res.ready;
    assign rx.ready = (q_cnt_reg <= 3'd1);

    assign b         = rx.rx_byte;
    assign shifted   = {shift_reg[23:0], b};
    assign name_end  = ({1'b0, name_cnt_reg} + 21'd1) >= {1'b0, name_len_reg};
    assign name_kind = is_dir_reg ? KIND_DNAME : KIND_FNAME;
    assign data_inc  = data_cnt_reg + 31'd1;
    assign data_last = (data_inc >= file_len_reg);
    assign dig_last  = (dig_cnt_reg == DIGEST_CNT_W'(DIGEST_CHARS - 1));

    // Name tail: held window bytes followed by the closing byte, packed left.
    always_comb
    begin
        a0 = b;
        a1 = 8'h00;
        a2 = 8'h00;
        if (fill_reg == 2'd2)
        begin
            a0 = win_reg[0];
            a1 = win_reg[1];
            a2 = b;
        end
        else if (fill_reg == 2'd1)
        begin
            a0 = win_reg[0];
            a1 = b;
        end
    end

    // Left-to-right cleaning of the tail: "../" then "./" at each position.
    always_comb
    begin
        c0 = a0;
        c1 = a1;
        c2 = a2;
        if (fill_reg == 2'd2)
        begin
            if (a0 == CHAR_DOT && a1 == CHAR_DOT && a2 == CHAR_SLSH)
            begin
                c0 = CHAR_SUBS;
                c1 = CHAR_SUBS;
                c2 = CHAR_SUBS;
            end
            else if (a0 == CHAR_DOT && a1 == CHAR_SLSH)
            begin
                c0 = CHAR_SUBS;
                c1 = CHAR_SUBS;
            end
            else if (a1 == CHAR_DOT && a2 == CHAR_SLSH)
            begin
                c1 = CHAR_SUBS;
                c2 = CHAR_SUBS;
            end
        end
        else if (fill_reg == 2'd1)
        begin
            if (a0 == CHAR_DOT && a1 == CHAR_SLSH)
            begin
                c0 = CHAR_SUBS;
                c1 = CHAR_SUBS;
            end
        end
    end

    // Parse step for the accepted byte
    always_comb
    begin
        phase_next    = phase_reg;
        is_dir_next   = is_dir_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        shift_next    = shift_reg;
        name_len_next = name_len_reg;
        name_cnt_next = name_cnt_reg;
        win_next[0]   = win_reg[0];
        win_next[1]   = win_reg[1];
        fill_next     = fill_reg;
        file_len_next = file_len_reg;
        data_cnt_next = data_cnt_reg;
        dig_cnt_next  = dig_cnt_reg;
        n_res         = 2'd0;
        res_item[0]   = '0;
        res_item[1]   = '0;
        res_item[2]   = '0;

        if (accept)
        begin
            unique case (phase_reg) inside
                PH_TYPE:
                begin
                    if (b == CHAR_FILE || b == CHAR_DIR)
                    begin
                        is_dir_next  = (b == CHAR_DIR);
                        hdr_cnt_next = 2'd0;
                        shift_next   = '0;
                        phase_next   = PH_NAMELEN;
                    end
                    else if (b == CHAR_STOP)
                    begin
                        phase_next  = PH_STOP;
                        n_res       = 2'd1;
                        res_item[0] = make_res(8'h00, KIND_EVENT, 1'b0, 1'b0, 1'b1, ERR_NONE);
                    end
                    else
                    begin
                        phase_next  = PH_ERROR;
                        n_res       = 2'd1;
                        res_item[0] = make_res(8'h00, KIND_EVENT, 1'b0, 1'b0, 1'b0, ERR_TYPE);
                    end
                end
                PH_NAMELEN:
                begin
                    shift_next = shifted;
                    if (hdr_cnt_reg == 2'd3)
                    begin
                        hdr_cnt_next = 2'd0;
                        // zero, above the limit, or negative (top bits set)
                        if (shifted == 32'd0 || shifted > {12'd0, max_name_reg})
                        begin
                            phase_next  = PH_ERROR;
                            n_res       = 2'd1;
                            res_item[0] = make_res(8'h00, KIND_EVENT, 1'b0, 1'b0, 1'b0,
                                                   ERR_NLEN);
                        end
                        else
                        begin
                            name_len_next = shifted[19:0];
                            name_cnt_next = '0;
                            fill_next     = 2'd0;
                            phase_next    = PH_NAME;
                        end
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_cnt_reg + 2'd1;
                    end
                end
                PH_NAME:
                begin
                    if (name_end)
                    begin
                        // flush everything held, last item closes the name
                        fill_next = 2'd0;
                        n_res     = fill_reg + 2'd1;
                        res_item[0] = make_res(c0, name_kind, fill_reg == 2'd0,
                                               (fill_reg == 2'd0) && is_dir_reg,
                                               1'b0, ERR_NONE);
                        res_item[1] = make_res(c1, name_kind, fill_reg == 2'd1,
                                               (fill_reg == 2'd1) && is_dir_reg,
                                               1'b0, ERR_NONE);
                        res_item[2] = make_res(c2, name_kind, 1'b1, is_dir_reg,
                                               1'b0, ERR_NONE);
                        if (is_dir_reg)
                        begin
                            phase_next = PH_TYPE;
                        end
                        else
                        begin
                            hdr_cnt_next = 2'd0;
                            shift_next   = '0;
                            phase_next   = PH_SIZE;
                        end
                    end
                    else
                    begin
                        name_cnt_next = name_cnt_reg + 20'd1;
                        if (fill_reg != 2'd2)
                        begin
                            win_next[fill_reg[0]] = b;
                            fill_next             = fill_reg + 2'd1;
                        end
                        else
                        begin
                            n_res = 2'd1;
                            if (win_reg[0] == CHAR_DOT && win_reg[1] == CHAR_DOT
                                && b == CHAR_SLSH)
                            begin
                                res_item[0] = make_res(CHAR_SUBS, name_kind, 1'b0, 1'b0,
                                                       1'b0, ERR_NONE);
                                win_next[0] = CHAR_SUBS;
                                win_next[1] = CHAR_SUBS;
                            end
                            else if (win_reg[0] == CHAR_DOT && win_reg[1] == CHAR_SLSH)
                            begin
                                res_item[0] = make_res(CHAR_SUBS, name_kind, 1'b0, 1'b0,
                                                       1'b0, ERR_NONE);
                                win_next[0] = CHAR_SUBS;
                                win_next[1] = b;
                            end
                            else
                            begin
                                res_item[0] = make_res(win_reg[0], name_kind, 1'b0, 1'b0,
                                                       1'b0, ERR_NONE);
                                win_next[0] = win_reg[1];
                                win_next[1] = b;
                            end
                        end
                    end
                end
                PH_SIZE:
                begin
                    shift_next = shifted;
                    if (hdr_cnt_reg == 2'd3)
                    begin
                        hdr_cnt_next = 2'd0;
                        if (shifted[31])
                        begin
                            phase_next  = PH_ERROR;
                            n_res       = 2'd1;
                            res_item[0] = make_res(8'h00, KIND_EVENT, 1'b0, 1'b0, 1'b0,
                                                   ERR_SIZE);
                        end
                        else
                        begin
                            file_len_next = shifted[30:0];
                            dig_cnt_next  = '0;
                            phase_next    = PH_DIGEST;
                        end
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_cnt_reg + 2'd1;
                    end
                end
                PH_DIGEST:
                begin
                    n_res       = 2'd1;
                    res_item[0] = make_res(b, KIND_DIGST, dig_last, 1'b0, 1'b0, ERR_NONE);
                    if (dig_last)
                    begin
                        phase_next = PH_SEP;
                    end
                    else
                    begin
                        dig_cnt_next = dig_cnt_reg + DIGEST_CNT_W'(1);
                    end
                end
                PH_SEP:
                begin
                    if (file_len_reg == 31'd0)
                    begin
                        // empty file: record closes on the separator
                        n_res       = 2'd1;
                        res_item[0] = make_res(8'h00, KIND_EVENT, 1'b0, 1'b1, 1'b0,
                                               ERR_NONE);
                        phase_next  = PH_TYPE;
                    end
                    else
                    begin
                        data_cnt_next = '0;
                        phase_next    = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    data_cnt_next = data_inc;
                    n_res         = 2'd1;
                    res_item[0]   = make_res(b, KIND_DATA, data_last, data_last, 1'b0,
                                             ERR_NONE);
                    if (data_last)
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_STOP, PH_ERROR:
                begin
                    // sticky: bytes are dropped
                end
                default:
                begin
                    phase_next = PH_ERROR;
                end
            endcase

            // mark the final item of this byte
            case (n_res)
                2'd1:    res_item[0].run_last = 1'b1;
                2'd2:    res_item[1].run_last = 1'b1;
                2'd3:    res_item[2].run_last = 1'b1;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_name_reg <= MAX_NAME_RST;
            phase_reg    <= PH_TYPE;
            is_dir_reg   <= 1'b0;
            hdr_cnt_reg  <= '0;
            shift_reg    <= '0;
            name_len_reg <= '0;
            name_cnt_reg <= '0;
            fill_reg     <= '0;
            file_len_reg <= '0;
            data_cnt_reg <= '0;
            dig_cnt_reg  <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            q_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_name_reg <= cfg_wdata;
            end
            phase_reg    <= phase_next;
            is_dir_reg   <= is_dir_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            shift_reg    <= shift_next;
            name_len_reg <= name_len_next;
            name_cnt_reg <= name_cnt_next;
            fill_reg     <= fill_next;
            file_len_reg <= file_len_next;
            data_cnt_reg <= data_cnt_next;
            dig_cnt_reg  <= dig_cnt_next;
            wr_ptr_reg   <= wr_ptr_reg + n_res;
            rd_ptr_reg   <= rd_ptr_reg + {1'b0, pop};
            q_cnt_reg    <= q_cnt_reg + {1'b0, n_res} - {2'b00, pop};
        end
    end

    // payload storage: window and queue entries
    always_ff @(posedge clk)
    begin
        win_reg[0] <= win_next[0];
        win_reg[1] <= win_next[1];
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < n_res)
            begin
                q_reg[wr_ptr_reg + 2'(i)] <= res_item[i];
            end
        end
    end

    assign res.valid       = (q_cnt_reg != 3'd0);
    assign res.out_byte    = q_reg[rd_ptr_reg].out_byte;
    assign res.byte_kind   = q_reg[rd_ptr_reg].byte_kind;
    assign res.field_last  = q_reg[rd_ptr_reg].field_last;
    assign res.record_done = q_reg[rd_ptr_reg].record_done;
    assign res.stop_seen   = q_reg[rd_ptr_reg].stop_seen;
    assign res.error_code  = q_reg[rd_ptr_reg].error_code;
    assign res.run_last    = q_reg[rd_ptr_reg].run_last;

endmodule

// File: rtl/core/frd_checker.sv
// ----------------------------------------------------------------------------
// frd_checker: port-level checks of the file record deframer
// Watches the result channel; bound to the top level below.
// ----------------------------------------------------------------------------
module frd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] res_out_byte,
    input logic       res_stop_seen,
    input logic [1:0] res_error_code,
    input logic       res_run_last
);
    import frd_pkg::*;

    // a stalled item stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result item dropped while stalled");

    // a stalled item keeps its byte
    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_out_byte))
        else $error("result byte changed while stalled");

    // stop and error are terminal: nothing follows them
    a_terminal: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && (res_stop_seen || res_error_code != ERR_NONE)
        |=> !res_valid)
        else $error("result item after stop or error");

    // stop and error items are single events with no payload
    a_event_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_stop_seen || res_error_code != ERR_NONE)
        |-> res_run_last && res_out_byte == 8'h00)
        else $error("malformed stop or error item");

endmodule

bind file_record_deframer frd_checker u_frd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_out_byte   (res.out_byte),
    .res_stop_seen  (res.stop_seen),
    .res_error_code (res.error_code),
    .res_run_last   (res.run_last)
);
